@@ src/epsc_pkg.sv @@
// ----------------------------------------------------------------------------
// epsc_pkg
// Shared types and constants for the encoder PI speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package epsc_pkg;

  typedef enum logic [1:0] {
    ACT_RIGHT = 2'd0,
    ACT_LEFT  = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  localparam logic MOTOR_RIGHT = 1'b0;
  localparam logic MOTOR_LEFT  = 1'b1;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KP = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KI = 2'd1;

  localparam int GAIN_BITS   = 16;
  localparam logic [GAIN_BITS-1:0] KP_RESET = 16'd256;
  localparam logic [GAIN_BITS-1:0] KI_RESET = 16'd0;

  localparam int TARGET_BITS = 16;
  localparam int INTEG_BITS  = 9;
  localparam int INTEG_LIMIT = 255;
  localparam int MAG_BITS    = 10;
  localparam int PWM_BITS    = 8;

  typedef struct packed {
    logic motor;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

@@ src/epsc_front.sv @@
// ----------------------------------------------------------------------------
// epsc_front
// Accepts items, keeps the position counters and turns each tick into two
// motor jobs (right, then left) carrying the speed error.
// ----------------------------------------------------------------------------
`default_nettype none

module epsc_front import epsc_pkg::*; #(
  parameter int COUNT_BITS = 16,
  parameter int ERR_BITS   = 17
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic [1:0]                   in_action,
  input  wire logic                         in_phase_b,
  input  wire logic signed [TARGET_BITS-1:0] in_target_right,
  input  wire logic signed [TARGET_BITS-1:0] in_target_left,
  input  wire logic                         q_full,
  output      logic                         push,
  output      logic [ERR_BITS+1:0]          push_data
);

  logic [COUNT_BITS-1:0] pos_rt_r, pos_rt_nxt, pos_lt_r, pos_lt_nxt;
  logic [COUNT_BITS-1:0] last_rt_r, last_rt_nxt, last_lt_r, last_lt_nxt;
  logic                  pend_r, pend_nxt;
  logic signed [ERR_BITS-1:0] pend_err_r, pend_err_nxt;

  logic                  acc;
  logic [COUNT_BITS-1:0] diff_rt, diff_lt;
  logic signed [ERR_BITS-1:0] err_rt, err_lt;

  assign in_stall = pend_r | q_full;

  always_comb begin
    acc     = in_valid & ~in_stall;
    diff_rt = pos_rt_r - last_rt_r;
    diff_lt = pos_lt_r - last_lt_r;
    err_rt  = ERR_BITS'(in_target_right) - ERR_BITS'(signed'(diff_rt));
    err_lt  = ERR_BITS'(in_target_left) - ERR_BITS'(signed'(diff_lt));

    pos_rt_nxt   = pos_rt_r;
    pos_lt_nxt   = pos_lt_r;
    last_rt_nxt  = last_rt_r;
    last_lt_nxt  = last_lt_r;
    pend_nxt     = pend_r;
    pend_err_nxt = pend_err_r;
    push         = 1'b0;
    push_data    = {MOTOR_LEFT, 1'b1, pend_err_r};

    if (pend_r && !q_full) begin
      push     = 1'b1;
      pend_nxt = 1'b0;
    end

    if (acc) begin
      case (action_t'(in_action))
        ACT_RIGHT: begin
          pos_rt_nxt = in_phase_b ? pos_rt_r + COUNT_BITS'(1) : pos_rt_r - COUNT_BITS'(1);
        end
        ACT_LEFT: begin
          pos_lt_nxt = in_phase_b ? pos_lt_r - COUNT_BITS'(1) : pos_lt_r + COUNT_BITS'(1);
        end
        ACT_TICK: begin
          last_rt_nxt  = pos_rt_r;
          last_lt_nxt  = pos_lt_r;
          push         = 1'b1;
          push_data    = {MOTOR_RIGHT, 1'b0, err_rt};
          pend_nxt     = 1'b1;
          pend_err_nxt = err_lt;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_rt_r  <= '0;
      pos_lt_r  <= '0;
      last_rt_r <= '0;
      last_lt_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      pos_rt_r  <= pos_rt_nxt;
      pos_lt_r  <= pos_lt_nxt;
      last_rt_r <= last_rt_nxt;
      last_lt_r <= last_lt_nxt;
      pend_r    <= pend_nxt;
    end
    pend_err_r <= pend_err_nxt;
  end

endmodule

`default_nettype wire

@@ src/epsc_queue.sv @@
// ----------------------------------------------------------------------------
// epsc_queue
// Small register FIFO between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module epsc_queue #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ src/epsc_back.sv @@
// ----------------------------------------------------------------------------
// epsc_back
// PI execution pipeline: integral update, gain products, sum, then
// truncation, limit and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module epsc_back import epsc_pkg::*; #(
  parameter int ERR_BITS       = 17,
  parameter int GAIN_FRAC_BITS = 8,
  parameter int DRIVE_LIMIT    = 255
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [GAIN_BITS-1:0]    cfg_data,
  input  wire logic                    q_empty,
  output      logic                    pop,
  input  wire logic [ERR_BITS+1:0]     pop_data,
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      logic                    out_motor,
  output      logic [PWM_BITS-1:0]     out_pwm_magnitude,
  output      logic                    out_direction,
  output      logic                    out_last
);

  localparam int PW  = ERR_BITS + GAIN_BITS + 1;
  localparam int IPW = INTEG_BITS + GAIN_BITS + 1;
  localparam int SW  = ((PW > IPW) ? PW : IPW) + 1;
  localparam int ISW = ERR_BITS + 1;
  localparam logic signed [ISW-1:0] ILIM_POS = ISW'(INTEG_LIMIT);
  localparam logic signed [ISW-1:0] ILIM_NEG = -ISW'(INTEG_LIMIT);

  logic [GAIN_BITS-1:0] kp_r, ki_r;
  logic signed [INTEG_BITS-1:0] integ_r [2];

  logic a_v_r, b_v_r, c_v_r, o_v_r;
  tag_t a_tag_r, b_tag_r, c_tag_r, o_tag_r;
  logic signed [ERR_BITS-1:0]   a_err_r;
  logic signed [INTEG_BITS-1:0] a_int_r;
  logic signed [PW-1:0]         b_pkp_r;
  logic signed [IPW-1:0]        b_pki_r;
  logic signed [SW-1:0]         c_sum_r;
  logic [PWM_BITS-1:0]          o_mag_r;
  logic                         o_dir_r;

  logic o_free, c_free, b_free, a_free;
  tag_t pop_tag;
  logic signed [ERR_BITS-1:0]   pop_err;
  logic signed [ISW-1:0]        isum;
  logic signed [INTEG_BITS-1:0] integ_nxt;
  logic [SW-1:0]                abs_sum, mag_full;
  logic [MAG_BITS-1:0]          mag;
  logic                         dir;

  always_comb begin
    o_free = ~o_v_r | ~out_stall;
    c_free = ~c_v_r | o_free;
    b_free = ~b_v_r | c_free;
    a_free = ~a_v_r | b_free;
    pop    = ~q_empty & a_free;

    pop_tag = tag_t'(pop_data[ERR_BITS+1:ERR_BITS]);
    pop_err = signed'(pop_data[ERR_BITS-1:0]);
    isum    = ISW'(pop_err) + ISW'(integ_r[pop_tag.motor]);
    if (isum > ILIM_POS) begin
      integ_nxt = INTEG_BITS'(ILIM_POS);
    end else if (isum < ILIM_NEG) begin
      integ_nxt = INTEG_BITS'(ILIM_NEG);
    end else begin
      integ_nxt = INTEG_BITS'(isum);
    end

    abs_sum  = c_sum_r[SW-1] ? SW'(-c_sum_r) : SW'(c_sum_r);
    mag_full = abs_sum >> GAIN_FRAC_BITS;
    mag      = (mag_full > SW'(DRIVE_LIMIT)) ? MAG_BITS'(DRIVE_LIMIT) : MAG_BITS'(mag_full);
    dir      = ~c_sum_r[SW-1] & (mag != '0);
  end

  assign out_valid         = o_v_r;
  assign out_motor         = o_tag_r.motor;
  assign out_last          = o_tag_r.last;
  assign out_pwm_magnitude = o_mag_r;
  assign out_direction     = o_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= KP_RESET;
      ki_r       <= KI_RESET;
      integ_r[0] <= '0;
      integ_r[1] <= '0;
      a_v_r      <= 1'b0;
      b_v_r      <= 1'b0;
      c_v_r      <= 1'b0;
      o_v_r      <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_KP) begin
        kp_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_KI) begin
        ki_r <= cfg_data;
      end
      if (pop) begin
        integ_r[pop_tag.motor] <= integ_nxt;
      end
      if (a_free) a_v_r <= pop;
      if (b_free) b_v_r <= a_v_r;
      if (c_free) c_v_r <= b_v_r;
      if (o_free) o_v_r <= c_v_r;
    end

    if (a_free) begin
      a_tag_r <= pop_tag;
      a_err_r <= pop_err;
      a_int_r <= integ_nxt;
    end
    if (b_free) begin
      b_tag_r <= a_tag_r;
      b_pkp_r <= $signed({1'b0, kp_r}) * a_err_r;
      b_pki_r <= $signed({1'b0, ki_r}) * a_int_r;
    end
    if (c_free) begin
      c_tag_r <= b_tag_r;
      c_sum_r <= SW'(b_pkp_r) + SW'(b_pki_r);
    end
    if (o_free) begin
      o_tag_r <= c_tag_r;
      o_mag_r <= mag[PWM_BITS-1:0];
      o_dir_r <= dir;
    end
  end

endmodule

`default_nettype wire

@@ src/encoder_pi_speed_control.sv @@
// ----------------------------------------------------------------------------
// encoder_pi_speed_control
// Two-motor quadrature encoder counter with a PI speed loop per motor.
//
// Input channel (in_valid / in_stall): an encoder edge for the right or left
// motor moves that motor's counter; a control tick carries both targets and
// yields two results, right then left, the left one flagged out_last.
// Result channel (out_valid / out_stall): motor, PWM magnitude, direction.
// Configuration: cfg_we writes kp (index 0) or ki (index 1), Q8.8 unsigned;
// write only while the block is idle.
// Throughput: one edge item a cycle unless in_stall is high; after a tick the
// input stalls until the front end has queued the left motor job.
// Result path: after the tick transfer the right result passes the queue and
// the four-stage PI pipeline (a, b, c, output registers); the left one follows.
// A four-entry queue separates the front end from the pipeline, so edges keep
// being counted while the result side is stalled until the queue fills.
// Reset (rst_n low, synchronous) clears counters, integrals and all valids
// and restores kp = 1.0, ki = 0.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_pi_speed_control import epsc_pkg::*; #(
  parameter int COUNT_BITS     = 16,
  parameter int GAIN_FRAC_BITS = 8,
  parameter int DRIVE_LIMIT    = 255
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [1:0]                    in_action,
  input  wire logic                          in_phase_b,
  input  wire logic signed [TARGET_BITS-1:0] in_target_right,
  input  wire logic signed [TARGET_BITS-1:0] in_target_left,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          out_motor,
  output      logic [PWM_BITS-1:0]           out_pwm_magnitude,
  output      logic                          out_direction,
  output      logic                          out_last,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [GAIN_BITS-1:0]          cfg_data
);

  localparam int ERR_BITS = ((COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS) + 1;
  localparam int QW       = ERR_BITS + 2;

  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  epsc_front #(
    .COUNT_BITS (COUNT_BITS),
    .ERR_BITS   (ERR_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_phase_b      (in_phase_b),
    .in_target_right (in_target_right),
    .in_target_left  (in_target_left),
    .q_full          (q_full),
    .push            (q_push),
    .push_data       (q_wdata)
  );

  epsc_queue #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  epsc_back #(
    .ERR_BITS       (ERR_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .DRIVE_LIMIT    (DRIVE_LIMIT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_empty           (q_empty),
    .pop               (q_pop),
    .pop_data          (q_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_motor         (out_motor),
    .out_pwm_magnitude (out_pwm_magnitude),
    .out_direction     (out_direction),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

@@ src/epsc_checker.sv @@
// ----------------------------------------------------------------------------
// epsc_checker
// Port-level checks for the encoder PI speed controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module epsc_checker import epsc_pkg::*; (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_motor,
  input wire logic [PWM_BITS-1:0]           out_pwm_magnitude,
  input wire logic                          out_direction,
  input wire logic                          out_last
);

  logic out_xfer;
  logic expect_left_r;

  assign out_xfer = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_left_r <= 1'b0;
    end else if (out_xfer) begin
      expect_left_r <= (out_motor == MOTOR_RIGHT);
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_motor) &&
      $stable(out_pwm_magnitude) && $stable(out_direction) && $stable(out_last))
    else $error("stalled result changed");

  a_last_is_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_motor))
    else $error("last flag does not match motor");

  a_pairs_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (out_motor == expect_left_r))
    else $error("results not paired right then left");

  a_zero_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pwm_magnitude == '0) |-> !out_direction)
    else $error("direction set with zero drive");

endmodule

bind encoder_pi_speed_control epsc_checker u_epsc_checker (.*);

`default_nettype wire

@@ dv/epsc_drive_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsc_drive_checker
// Watches the input, result and gain-write ports of the encoder PI speed
// controller. It keeps its own wheel counters, integrals and gains, works out
// the two drive results of every control tick and compares each result
// transfer, field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------

module epsc_drive_checker import epsc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int DRIVE_LIMIT    = 255
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic                          in_phase_b,
  input  logic signed [TARGET_BITS-1:0] in_target_right,
  input  logic signed [TARGET_BITS-1:0] in_target_left,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_motor,
  input  logic [PWM_BITS-1:0]           out_pwm_magnitude,
  input  logic                          out_direction,
  input  logic                          out_last,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [GAIN_BITS-1:0]          cfg_data,
  input  logic                          run_done,
  output int                            fail_count,
  output int                            drives_pending
);

  typedef struct {
    logic                motor;
    logic [PWM_BITS-1:0] pwm;
    logic                dir;
    logic                last;
  } drive_t;

  localparam int PRINT_CAP = 100;

  drive_t               drive_q[$];
  logic [15:0]          wheel_count [2];
  logic [15:0]          wheel_mark  [2];
  int                   integ       [2];
  logic [GAIN_BITS-1:0] kp_gain;
  logic [GAIN_BITS-1:0] ki_gain;
  int                   mismatches = 0;
  bit                   leftovers_done = 0;

  assign fail_count = mismatches;

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [PWM_BITS-1:0] got,
                             input logic [PWM_BITS-1:0] exp);
    if (got !== exp) report($sformatf("%s got %0d expected %0d", name, got, exp));
  endtask

  // One PI update for wheel m; speed is the wrapped count change since the last tick
  task automatic close_loop(input int m, input logic signed [TARGET_BITS-1:0] target,
                            input logic is_last);
    logic signed [15:0] speed;
    longint             err;
    longint             acc;
    longint             mag;
    drive_t             d;
    speed = wheel_count[m] - wheel_mark[m];
    wheel_mark[m] = wheel_count[m];
    err = longint'(target) - longint'(speed);
    acc = integ[m] + err;
    if (acc > INTEG_LIMIT) acc = INTEG_LIMIT;
    else if (acc < -INTEG_LIMIT) acc = -INTEG_LIMIT;
    integ[m] = int'(acc);
    acc = longint'(kp_gain) * err + longint'(ki_gain) * integ[m];
    mag = (acc < 0 ? -acc : acc) >> GAIN_FRAC_BITS;
    if (mag > DRIVE_LIMIT) mag = DRIVE_LIMIT;
    d.motor = (m == 0) ? MOTOR_RIGHT : MOTOR_LEFT;
    d.pwm   = mag[PWM_BITS-1:0];
    d.dir   = (acc >= 0) && (mag != 0);
    d.last  = is_last;
    drive_q.push_back(d);
  endtask

  always @(posedge clk) begin : track
    drive_t got;
    if (!rst_n) begin
      wheel_count = '{16'd0, 16'd0};
      wheel_mark  = '{16'd0, 16'd0};
      integ       = '{0, 0};
      kp_gain     = KP_RESET;
      ki_gain     = KI_RESET;
      drive_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          report("result transfer with nothing outstanding");
        end else begin
          got = drive_q.pop_front();
          check_field("motor", out_motor, got.motor);
          check_field("pwm_magnitude", out_pwm_magnitude, got.pwm);
          check_field("direction", out_direction, got.dir);
          check_field("last", out_last, got.last);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_KP) kp_gain = cfg_data;
        else if (cfg_index == REG_KI) ki_gain = cfg_data;
      end
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_RIGHT: wheel_count[0] = in_phase_b ? wheel_count[0] + 16'd1
                                                 : wheel_count[0] - 16'd1;
          ACT_LEFT:  wheel_count[1] = in_phase_b ? wheel_count[1] - 16'd1
                                                 : wheel_count[1] + 16'd1;
          ACT_TICK: begin
            close_loop(0, in_target_right, 1'b0);
            close_loop(1, in_target_left, 1'b1);
          end
          default: ;
        endcase
      end
      if (run_done && !leftovers_done) begin
        leftovers_done = 1;
        while (drive_q.size() != 0) begin
          got = drive_q.pop_front();
          report($sformatf("motor %0d result never arrived", got.motor));
        end
      end
    end
    drives_pending <= drive_q.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the encoder PI speed controller. A short directed
// run covers counter wrap, both wheels in both directions, target extremes,
// the unused action code and gain extremes; then random phases of encoder
// edge bursts closed by ticks, each under fresh gains, with random gaps on
// the input and random stalls on the results. Checking is in the checker.
// ----------------------------------------------------------------------------

module testbench;
  import epsc_pkg::*;

  localparam logic [1:0]              ACT_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;
  localparam logic signed [15:0]      TGT_MAX      = 16'sh7FFF;
  localparam logic signed [15:0]      TGT_MIN      = 16'sh8000;
  localparam logic [GAIN_BITS-1:0]    GAIN_MAX     = 16'hFFFF;
  localparam int ITEM_GOAL     = 1900;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    in_action;
  logic                          in_phase_b;
  logic signed [TARGET_BITS-1:0] in_target_right;
  logic signed [TARGET_BITS-1:0] in_target_left;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_motor;
  logic [PWM_BITS-1:0]           out_pwm_magnitude;
  logic                          out_direction;
  logic                          out_last;
  logic                          cfg_we;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [GAIN_BITS-1:0]          cfg_data;
  logic                          run_done;
  int                            check_failures;
  int                            drives_pending;
  int                            items_sent = 0;
  bit                            gaps_on = 0;
  int                            stall_mode = 1;
  int                            stall_hold = 0;

  encoder_pi_speed_control u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_phase_b        (in_phase_b),
    .in_target_right   (in_target_right),
    .in_target_left    (in_target_left),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_motor         (out_motor),
    .out_pwm_magnitude (out_pwm_magnitude),
    .out_direction     (out_direction),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  epsc_drive_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_phase_b        (in_phase_b),
    .in_target_right   (in_target_right),
    .in_target_left    (in_target_left),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_motor         (out_motor),
    .out_pwm_magnitude (out_pwm_magnitude),
    .out_direction     (out_direction),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .run_done          (run_done),
    .fail_count        (check_failures),
    .drives_pending    (drives_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result-side back-pressure: mode 0 never stalls, mode 2 adds long stalls
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (stall_mode == 0 || $urandom_range(0, 99) < 55) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 8);
    end else begin
      out_stall  <= 1'b1;
      stall_hold <= (stall_mode == 2 && $urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                                  : $urandom_range(0, 3);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [15:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'(int'($urandom_range(0, 60)) - 30);
    if (r < 90) return 16'($urandom);
    case ($urandom_range(0, 4))
      0:       return TGT_MAX;
      1:       return TGT_MIN;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic send(input logic [1:0] act, input logic b,
                      input logic signed [15:0] tr, input logic signed [15:0] tl);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_phase_b      <= b;
    in_target_right <= tr;
    in_target_left  <= tl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drives_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_gains(input logic [GAIN_BITS-1:0] kp, input logic [GAIN_BITS-1:0] ki,
                               input bit stray);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KP;
    cfg_data  <= kp;
    @(posedge clk);
    cfg_index <= REG_KI;
    cfg_data  <= ki;
    @(posedge clk);
    if (stray) begin
      // out-of-range index, must leave both gains alone
      cfg_index <= $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
      cfg_data  <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [GAIN_BITS-1:0] kp_pick;
    logic [GAIN_BITS-1:0] ki_pick;
    int                   phase_end;
    int                   burst;
    int                   right_up;
    int                   left_up;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_RIGHT;
    in_phase_b      = 1'b0;
    in_target_right = '0;
    in_target_left  = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_KP;
    cfg_data        = '0;
    run_done        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset gains, counter wrap below zero, ignored fields
    send(ACT_TICK, 1'b0, 16'sd0, 16'sd0);
    send(ACT_RIGHT, 1'b0, TGT_MAX, TGT_MIN);
    send(ACT_RIGHT, 1'b1, TGT_MIN, TGT_MAX);
    send(ACT_RIGHT, 1'b0, 16'sd0, 16'sd0);
    send(ACT_LEFT, 1'b1, TGT_MAX, TGT_MAX);
    send(ACT_LEFT, 1'b0, 16'sd0, 16'sd0);
    send(ACT_LEFT, 1'b1, TGT_MIN, TGT_MIN);
    send(ACT_UNUSED, 1'b1, TGT_MAX, -16'sd1);
    send(ACT_TICK, 1'b1, TGT_MAX, TGT_MIN);
    send(ACT_TICK, 1'b0, TGT_MIN, TGT_MAX);
    // wheels driven opposite ways so the two direction bits differ
    send(ACT_LEFT, 1'b1, 16'sd0, 16'sd0);
    send(ACT_LEFT, 1'b1, 16'sd0, 16'sd0);
    send(ACT_RIGHT, 1'b1, 16'sd0, 16'sd0);
    send(ACT_RIGHT, 1'b1, 16'sd0, 16'sd0);
    send(ACT_TICK, 1'b0, -16'sd5, 16'sd5);
    send(ACT_TICK, 1'b1, 16'sd5, -16'sd5);
    wait_idle();
    program_gains('0, '0, 1'b1);
    send(ACT_TICK, 1'b0, 16'sd100, -16'sd100);
    wait_idle();
    program_gains(GAIN_MAX, GAIN_MAX, 1'b1);
    send(ACT_TICK, 1'b1, 16'sd1, -16'sd1);
    send(ACT_TICK, 1'b0, TGT_MAX, TGT_MIN);
    send(ACT_TICK, 1'b0, 16'sd0, 16'sd0);
    wait_idle();
    program_gains(KP_RESET, 16'd32, 1'b0);
    send(ACT_TICK, 1'b1, 16'sd3, -16'sd3);

    // random phases: edge bursts with random content, each closed by a tick
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: begin
          kp_pick = KP_RESET;
          ki_pick = 16'($urandom_range(0, 64));
        end
        1: begin
          kp_pick = 16'($urandom_range(0, 1024));
          ki_pick = 16'($urandom_range(0, 512));
        end
        2:       begin kp_pick = 16'($urandom);           ki_pick = 16'($urandom);          end
        3:       begin kp_pick = '0;                      ki_pick = GAIN_MAX;               end
        4:       begin kp_pick = GAIN_MAX;                ki_pick = '0;                     end
        default: begin
          kp_pick = 16'($urandom_range(0, 300));
          ki_pick = 16'($urandom_range(0, 40));
        end
      endcase
      program_gains(kp_pick, ki_pick, $urandom_range(0, 3) == 0);
      gaps_on    = $urandom_range(0, 3) != 0;
      stall_mode = $urandom_range(0, 2);
      phase_end  = items_sent + $urandom_range(150, 300);
      while (items_sent < phase_end) begin
        burst    = $urandom_range(0, 12);
        right_up = $urandom_range(0, 100);
        left_up  = $urandom_range(0, 100);
        for (int i = 0; i < burst; i++) begin
          if ($urandom_range(0, 1))
            send(ACT_RIGHT, $urandom_range(0, 99) < right_up, 16'($urandom), 16'($urandom));
          else
            send(ACT_LEFT, $urandom_range(0, 99) < left_up, 16'($urandom), 16'($urandom));
          if ($urandom_range(0, 49) == 0)
            send(ACT_UNUSED, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
        end
        send(ACT_TICK, 1'($urandom_range(0, 1)), pick_target(), pick_target());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (drives_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (check_failures == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
